// ===== design/tbq_pkg.sv =====
package tbq_pkg;

   localparam int unsigned COORD_W    = 16;
   localparam int unsigned DEBOUNCE_W = 4;
   localparam int unsigned HOLD_W     = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Register map, in index order
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AREA_LEFT      = 3'd0,
      CSR_AREA_TOP       = 3'd1,
      CSR_AREA_WIDTH     = 3'd2,
      CSR_AREA_HEIGHT    = 3'd3,
      CSR_ACTIVE         = 3'd4,
      CSR_DEBOUNCE_COUNT = 3'd5,
      CSR_HOLD_COUNT     = 3'd6
   } csr_index_type;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 4'd3;
   localparam logic [HOLD_W-1:0]     HOLD_RESET     = 8'd30;

   typedef struct packed {
      logic [COORD_W-1:0]    area_left;
      logic [COORD_W-1:0]    area_top;
      logic [COORD_W-1:0]    area_width;
      logic [COORD_W-1:0]    area_height;
      logic                  active;
      logic [DEBOUNCE_W-1:0] debounce_count;
      logic [HOLD_W-1:0]     hold_count;
   } cfg_type;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] stable_count;
      logic                  pressed;
      logic                  held;
      logic                  short_press;
      logic [HOLD_W-1:0]     hold_ticks;
   } btn_state_type;

   typedef struct packed {
      logic pressed;
      logic held;
      logic short_press;
      logic press_event;
      logic release_event;
      logic changed;
      logic beep_request;
   } result_type;

endpackage

// ===== design/tbq_if.sv =====
interface tbq_req_if;
   import tbq_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] touch_x;
   logic [COORD_W-1:0] touch_y;

   modport source (output valid, output touch_x, output touch_y, input ready);
   modport sink   (input valid, input touch_x, input touch_y, output ready);
endinterface

interface tbq_rsp_if;
   logic valid;
   logic ready;
   logic pressed;
   logic held;
   logic short_press;
   logic press_event;
   logic release_event;
   logic changed;
   logic beep_request;

   modport source (output valid, output pressed, output held, output short_press,
                   output press_event, output release_event, output changed,
                   output beep_request, input ready);
   modport sink   (input valid, input pressed, input held, input short_press,
                   input press_event, input release_event, input changed,
                   input beep_request, output ready);
endinterface

// ===== design/tbq_step.sv =====
module tbq_step
   import tbq_pkg::*;
(
   input  cfg_type            cfg,
   input  btn_state_type      state_cur,
   input  logic [COORD_W-1:0] touch_x,
   input  logic [COORD_W-1:0] touch_y,
   output btn_state_type      state_nxt,
   output result_type         result
);

   logic [COORD_W:0]      x_limit;
   logic [COORD_W:0]      y_limit;
   logic                  hit;
   logic                  agree;
   logic [DEBOUNCE_W-1:0] threshold;
   logic [DEBOUNCE_W-1:0] count_step;
   logic                  toggle;
   logic                  press_ev;
   logic                  release_ev;

   // 17-bit limits never wrap
   assign x_limit = {1'b0, cfg.area_left} + {1'b0, cfg.area_width};
   assign y_limit = {1'b0, cfg.area_top} + {1'b0, cfg.area_height};
   assign hit = (touch_x > cfg.area_left) && ({1'b0, touch_x} < x_limit) &&
                (touch_y > cfg.area_top)  && ({1'b0, touch_y} < y_limit);

   assign threshold  = (cfg.debounce_count == '0) ? DEBOUNCE_W'(1) : cfg.debounce_count;
   assign agree      = state_cur.pressed ? hit : !hit;
   assign count_step = agree ? '0 : state_cur.stable_count + DEBOUNCE_W'(1);
   assign toggle     = (count_step == threshold);

   always_comb begin
      state_nxt  = state_cur;
      press_ev   = 1'b0;
      release_ev = 1'b0;
      if (cfg.active) begin
         state_nxt.stable_count = count_step;
         if (toggle) begin
            state_nxt.stable_count = '0;
            state_nxt.held         = 1'b0;
            state_nxt.hold_ticks   = '0;
            if (!state_cur.pressed) begin
               state_nxt.pressed     = 1'b1;
               state_nxt.short_press = 1'b0;
               press_ev              = 1'b1;
            end else begin
               state_nxt.pressed = 1'b0;
               if (!state_cur.held) begin
                  state_nxt.short_press = 1'b1;
               end
               release_ev = 1'b1;
            end
         end else if (state_cur.pressed) begin
            if (state_cur.hold_ticks >= cfg.hold_count) begin
               state_nxt.held = 1'b1;
            end else begin
               state_nxt.hold_ticks = state_cur.hold_ticks + HOLD_W'(1);
            end
         end
      end
   end

   always_comb begin
      result.pressed       = state_nxt.pressed;
      result.held          = state_nxt.held;
      result.short_press   = state_nxt.short_press;
      result.press_event   = press_ev;
      result.release_event = release_ev;
      result.changed       = press_ev | release_ev;
      result.beep_request  = press_ev;
   end

endmodule

// ===== design/touch_button_qualifier_core.sv =====
// Touch button qualifier. Each req transaction carries one touch sample
// (touch_x, touch_y) and yields exactly one rsp transaction with the debounced
// pressed level, the long-press held flag, the sticky short-press flag and
// one-sample pulses for press, release, change and beep request (the beep is
// meant as a short confirmation tone of about 50 ms and rises with press).
// A sample hits when it lies strictly inside the rectangle set by the area
// registers; debounce_count consecutive disagreeing samples toggle the level
// (0 acts as 1), and hold_count + 1 further pressed samples raise held. With active at 0
// samples leave all state alone and report the stored levels, pulses low.
// Rate: one transaction per cycle sustained while rsp ready stays high. The
// sample lands in the input register at the accepting edge and moves into the
// result register once that register is empty or is draining; rsp valid is
// driven straight from the result register.
// The debounce and hold update is a single short pass between those two
// registers. No clearing pass after reset. Write csr_* only while no
// transaction is in flight.
module touch_button_qualifier_core
   import tbq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tbq_req_if.sink               req_chan,
   tbq_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type            cfg_ff;
   btn_state_type      state_ff;
   btn_state_type      state_in;
   result_type         result_in;
   result_type         result_ff;

   logic               in_valid_ff;
   logic [COORD_W-1:0] in_x_ff;
   logic [COORD_W-1:0] in_y_ff;
   logic               out_valid_ff;
   logic               advance;
   logic               req_take;

   // Advance the input stage whenever the result register is empty or drains now
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   // Configuration registers; indexes past the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.area_left      <= '0;
         cfg_ff.area_top       <= '0;
         cfg_ff.area_width     <= '0;
         cfg_ff.area_height    <= '0;
         cfg_ff.active         <= 1'b0;
         cfg_ff.debounce_count <= DEBOUNCE_RESET;
         cfg_ff.hold_count     <= HOLD_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_AREA_LEFT:      cfg_ff.area_left      <= csr_wdata;
            CSR_AREA_TOP:       cfg_ff.area_top       <= csr_wdata;
            CSR_AREA_WIDTH:     cfg_ff.area_width     <= csr_wdata;
            CSR_AREA_HEIGHT:    cfg_ff.area_height    <= csr_wdata;
            CSR_ACTIVE:         cfg_ff.active         <= csr_wdata[0];
            CSR_DEBOUNCE_COUNT: cfg_ff.debounce_count <= csr_wdata[DEBOUNCE_W-1:0];
            CSR_HOLD_COUNT:     cfg_ff.hold_count     <= csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: hold the sample until the result stage can take it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_x_ff <= req_chan.touch_x;
         in_y_ff <= req_chan.touch_y;
      end
   end

   tbq_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .touch_x   (in_x_ff),
      .touch_y   (in_y_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // Commit the button state only when the sample moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pressed       = result_ff.pressed;
   assign rsp_chan.held          = result_ff.held;
   assign rsp_chan.short_press   = result_ff.short_press;
   assign rsp_chan.press_event   = result_ff.press_event;
   assign rsp_chan.release_event = result_ff.release_event;
   assign rsp_chan.changed       = result_ff.changed;
   assign rsp_chan.beep_request  = result_ff.beep_request;

endmodule

// ===== design/tbq_checker.sv =====
module tbq_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_pressed,
   input logic rsp_held,
   input logic rsp_short_press,
   input logic rsp_press_event,
   input logic rsp_release_event,
   input logic rsp_changed,
   input logic rsp_beep_request
);

   // Check that no result is valid right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // Hold a stalled result
   a_rsp_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_pressed, rsp_held,
         rsp_short_press, rsp_press_event, rsp_release_event, rsp_changed,
         rsp_beep_request}))
      else $error("stalled rsp changed");

   a_event_coherent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_changed == (rsp_press_event || rsp_release_event)) &&
                    (rsp_beep_request == rsp_press_event) &&
                    !(rsp_press_event && rsp_release_event))
      else $error("event pulses disagree");

   a_level_follows_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_press_event || (rsp_pressed && !rsp_short_press)) &&
                    (!rsp_release_event || (!rsp_pressed && !rsp_held)))
      else $error("level disagrees with press or release");

   a_held_needs_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_held |-> rsp_pressed)
      else $error("held while released");

endmodule

bind touch_button_qualifier_core tbq_checker u_tbq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_pressed       (rsp_chan.pressed),
   .rsp_held          (rsp_chan.held),
   .rsp_short_press   (rsp_chan.short_press),
   .rsp_press_event   (rsp_chan.press_event),
   .rsp_release_event (rsp_chan.release_event),
   .rsp_changed       (rsp_chan.changed),
   .rsp_beep_request  (rsp_chan.beep_request)
);
